[design/adaptive_replacement_policy_selector_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive replacement policy selector
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_REPLACEMENT_POLICY_SELECTOR_DEFINES_SVH
`define ADAPTIVE_REPLACEMENT_POLICY_SELECTOR_DEFINES_SVH

// consequent must hold in the same cycle
`define ARPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arps checker: same-cycle property failed");

// consequent must hold in the next cycle
`define ARPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arps checker: next-cycle property failed");

`endif

[design/arps_pkg.sv]
// ----------------------------------------------------------------------------
// arps_pkg
// Types, codes and constants shared by the policy selector modules.
// ----------------------------------------------------------------------------
package arps_pkg;

  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int PCT_W  = 7;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 33;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_ACCESS  = 2'd1;
  localparam logic [1:0] KIND_EVICT   = 2'd2;
  localparam logic [1:0] KIND_REQUEST = 2'd3;

  localparam logic [1:0] POL_MRU  = 2'd0;
  localparam logic [1:0] POL_FIFO = 2'd1;
  localparam logic [1:0] POL_LRU  = 2'd2;

  localparam logic [1:0] REG_HIT_THR     = 2'd0;
  localparam logic [1:0] REG_MIN_SAMPLES = 2'd1;
  localparam logic [1:0] REG_MIN_DWELL   = 2'd2;
  localparam logic [1:0] REG_CHECK_INT   = 2'd3;

  localparam logic [PCT_W-1:0] SEQ_HI    = 7'd80;
  localparam logic [PCT_W-1:0] ONCE_HI   = 7'd60;
  localparam logic [PCT_W-1:0] ONCE_LO   = 7'd30;
  localparam logic [SUM_W-1:0] AVGH_LO   = 48'd2;
  localparam logic [SUM_W-1:0] AVGH_HI   = 48'd5;
  localparam logic [SUM_W-1:0] REUSE_MAX = 48'd50000;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [PCT_W-1:0]  RST_HIT_THR     = 7'd30;
  localparam logic [CNT_W-1:0]  RST_MIN_SAMPLES = 32'd1000;
  localparam logic [CNT_W-1:0]  RST_MIN_DWELL   = 32'd10000;
  localparam logic [15:0]       RST_CHECK_INT   = 16'd1000;

  typedef enum logic [3:0] {
    OP_MOD, OP_HIT, OP_ONCE, OP_SEQ, OP_AVGH, OP_AVGR,
    OP_RATE0, OP_RATE1, OP_RATE2, OP_DIRTY
  } div_op_t;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_READ     = 7'b0000100,
    S_UPDATE   = 7'b0001000,
    S_DIV_GO   = 7'b0010000,
    S_DIV_WAIT = 7'b0100000,
    S_GATE     = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    accept;
    logic    update;
    logic    div_start;
    logic    latch;
    logic    emit;
    logic    do_switch;
    div_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic gate_ok;
    logic hit_low;
    logic switch_needed;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

[design/arps_div.sv]
// ----------------------------------------------------------------------------
// arps_div
// Restoring divider, one quotient bit per cycle; zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module arps_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [arps_pkg::DIV_NW-1:0]  num,
  input  logic [arps_pkg::DIV_DW-1:0]  den,
  output logic                         done,
  output logic [arps_pkg::DIV_NW-1:0]  quot,
  output logic [arps_pkg::DIV_DW-1:0]  rem
);

  localparam int NW = arps_pkg::DIV_NW;
  localparam int DW = arps_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_sh;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, q_sh[NW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1)) && !start;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_sh  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run) begin
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        q_sh  <= {q_sh[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        q_sh  <= {q_sh[NW-2:0], 1'b0};
      end
    end
  end

  assign quot = (den_r == '0) ? '0 : q_sh;
  assign rem  = rem_r;

endmodule

[design/arps_datapath.sv]
// ----------------------------------------------------------------------------
// arps_datapath
// Slot metadata memory, workload counters, ratio unit and result registers.
// ----------------------------------------------------------------------------
module arps_datapath #(
  parameter int SLOTS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  arps_pkg::cmd_t     cmd,
  output arps_pkg::sts_t     sts,
  input  logic [1:0]         kind,
  input  logic [11:0]        slot,
  input  logic [31:0]        file_id,
  input  logic [31:0]        page_offset,
  input  logic               dirty,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [1:0]         policy,
  output logic               switched,
  output logic [1:0]         prev_policy,
  output logic [6:0]         win_hit_pct,
  output logic [31:0]        window_accesses,
  output logic [6:0]         single_use_pct,
  output logic [6:0]         seq_run_pct,
  output logic [31:0]        hits_per_evict,
  output logic [31:0]        reuse_gap,
  output logic [6:0]         dirty_evict_pct,
  output logic [6:0]         prev_policy_pct,
  output logic [31:0]        switch_time
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = 1 + 2 * arps_pkg::CNT_W;
  localparam int CW = arps_pkg::CNT_W;
  localparam int SW = arps_pkg::SUM_W;
  localparam int PW = arps_pkg::PCT_W;

  // configuration
  logic [PW-1:0] hit_thr;
  logic [CW-1:0] sample_floor;
  logic [CW-1:0] min_dwell;
  logic [15:0]   check_int;

  // captured item
  logic [1:0]  kind_q;
  logic [11:0] slot_q;
  logic [31:0] file_q;
  logic [31:0] page_q;
  logic        dirty_q;

  // metadata memory: {valid, last access, access count}
  logic [MW-1:0] meta [SLOTS];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic          wr_en;
  logic [MW-1:0] wr_data;
  logic          has_slot;
  logic          r_valid;
  logic [CW-1:0] r_last;
  logic [CW-1:0] r_cnt;

  // counters
  logic [CW-1:0] ltime, wacc, whit, once_cnt, multi_cnt, seq_cnt, rand_cnt;
  logic [SW-1:0] hit_total, reuse_total;
  logic [CW-1:0] evicted_cnt, reuse_cnt, evict_cnt, dirty_cnt;
  logic [CW-1:0] pol_hit [3];
  logic [CW-1:0] pol_miss [3];
  logic [1:0]    active;
  logic [CW-1:0] last_switch;
  logic [31:0]   prev_file, prev_page;
  logic          seq_hit;

  // ratio results
  logic          mod_zero;
  logic [PW-1:0] hit_pct, once_pct, seq_pct, dirty_pct;
  logic [PW-1:0] rate [3];
  logic [SW-1:0] avgh, avgr;

  // divider operands
  logic [CW-1:0]             sel_part;
  logic [arps_pkg::DIV_DW-1:0] sel_total;
  logic [arps_pkg::DIV_NW-1:0] div_num;
  logic [arps_pkg::DIV_DW-1:0] div_den;
  logic                      use_pct;
  logic                      div_done;
  logic [arps_pkg::DIV_NW-1:0] div_quot;
  logic [arps_pkg::DIV_DW-1:0] div_rem;
  logic [1:0]                next_pol;

  assign has_slot = (32'(slot_q) < 32'(SLOTS));
  assign addr     = AW'(slot_q);
  assign r_valid  = rd_q[MW-1];
  assign r_last   = rd_q[2*CW-1:CW];
  assign r_cnt    = rd_q[CW-1:0];
  assign seq_hit  = (file_q == prev_file) && ({1'b0, page_q} == {1'b0, prev_page} + 33'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_thr      <= arps_pkg::RST_HIT_THR;
      sample_floor <= arps_pkg::RST_MIN_SAMPLES;
      min_dwell    <= arps_pkg::RST_MIN_DWELL;
      check_int    <= arps_pkg::RST_CHECK_INT;
    end else if (cfg_we) begin
      case (cfg_index)
        arps_pkg::REG_HIT_THR:     hit_thr      <= cfg_data[PW-1:0];
        arps_pkg::REG_MIN_SAMPLES: sample_floor <= cfg_data;
        arps_pkg::REG_MIN_DWELL:   min_dwell    <= cfg_data;
        arps_pkg::REG_CHECK_INT:   check_int    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q  <= kind;
      slot_q  <= slot;
      file_q  <= file_id;
      page_q  <= page_offset;
      dirty_q <= dirty;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !sts.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_q;
    if (cmd.update && has_slot) begin
      case (kind_q)
        arps_pkg::KIND_ADD: begin
          wr_en   = 1'b1;
          wr_data = {1'b1, ltime, {CW{1'b0}}};
        end
        arps_pkg::KIND_ACCESS: begin
          wr_en   = r_valid;
          wr_data = {1'b1, ltime, arps_pkg::sat_inc32(r_cnt)};
        end
        arps_pkg::KIND_EVICT: begin
          wr_en   = r_valid;
          wr_data = {1'b0, r_last, r_cnt};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta[clr_addr] <= '0;
    end else if (wr_en) begin
      meta[addr] <= wr_data;
    end
    rd_q <= meta[addr];
  end

  // event counters, switch commit
  always_ff @(posedge clk) begin
    if (rst) begin
      ltime       <= '0;
      wacc        <= '0;
      whit        <= '0;
      once_cnt    <= '0;
      multi_cnt   <= '0;
      seq_cnt     <= '0;
      rand_cnt    <= '0;
      hit_total   <= '0;
      reuse_total <= '0;
      evicted_cnt <= '0;
      reuse_cnt   <= '0;
      evict_cnt   <= '0;
      dirty_cnt   <= '0;
      pol_hit     <= '{default: '0};
      pol_miss    <= '{default: '0};
      active      <= arps_pkg::POL_MRU;
      last_switch <= '0;
      prev_file   <= '0;
      prev_page   <= '0;
    end else if (cmd.update) begin
      case (kind_q)
        arps_pkg::KIND_ADD: begin
          if (seq_hit) begin
            seq_cnt <= arps_pkg::sat_inc32(seq_cnt);
          end else begin
            rand_cnt <= arps_pkg::sat_inc32(rand_cnt);
          end
          prev_file        <= file_q;
          prev_page        <= page_q;
          wacc             <= arps_pkg::sat_inc32(wacc);
          pol_miss[active] <= arps_pkg::sat_inc32(pol_miss[active]);
          ltime            <= arps_pkg::sat_inc32(ltime);
        end
        arps_pkg::KIND_ACCESS: begin
          if (has_slot && r_valid) begin
            if (r_cnt != '0) begin
              reuse_total <= arps_pkg::sat_add48(reuse_total, ltime - r_last);
              reuse_cnt   <= arps_pkg::sat_inc32(reuse_cnt);
            end
            whit            <= arps_pkg::sat_inc32(whit);
            wacc            <= arps_pkg::sat_inc32(wacc);
            pol_hit[active] <= arps_pkg::sat_inc32(pol_hit[active]);
            ltime           <= arps_pkg::sat_inc32(ltime);
          end
        end
        arps_pkg::KIND_EVICT: begin
          if (has_slot && r_valid) begin
            if (r_cnt <= 32'd1) begin
              once_cnt <= arps_pkg::sat_inc32(once_cnt);
            end else begin
              multi_cnt <= arps_pkg::sat_inc32(multi_cnt);
            end
            hit_total   <= arps_pkg::sat_add48(hit_total, r_cnt);
            evicted_cnt <= arps_pkg::sat_inc32(evicted_cnt);
          end
          if (dirty_q) begin
            dirty_cnt <= arps_pkg::sat_inc32(dirty_cnt);
          end
          evict_cnt <= arps_pkg::sat_inc32(evict_cnt);
        end
        default: ;
      endcase
    end else if (cmd.emit && cmd.do_switch) begin
      active      <= next_pol;
      last_switch <= ltime;
      wacc        <= '0;
      whit        <= '0;
    end
  end

  // divider operand select
  always_comb begin
    sel_part  = '0;
    sel_total = '0;
    use_pct   = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      arps_pkg::OP_MOD: begin
        use_pct = 1'b0;
        div_num = {16'd0, wacc};
        div_den = (check_int == '0) ? 33'd1 : {17'd0, check_int};
      end
      arps_pkg::OP_HIT: begin
        sel_part  = whit;
        sel_total = {1'b0, wacc};
      end
      arps_pkg::OP_ONCE: begin
        sel_part  = once_cnt;
        sel_total = {1'b0, once_cnt} + {1'b0, multi_cnt};
      end
      arps_pkg::OP_SEQ: begin
        sel_part  = seq_cnt;
        sel_total = {1'b0, seq_cnt} + {1'b0, rand_cnt};
      end
      arps_pkg::OP_AVGH: begin
        use_pct = 1'b0;
        div_num = hit_total;
        div_den = {1'b0, evicted_cnt};
      end
      arps_pkg::OP_AVGR: begin
        use_pct = 1'b0;
        div_num = reuse_total;
        div_den = {1'b0, reuse_cnt};
      end
      arps_pkg::OP_RATE0: begin
        sel_part  = pol_hit[0];
        sel_total = {1'b0, pol_hit[0]} + {1'b0, pol_miss[0]};
      end
      arps_pkg::OP_RATE1: begin
        sel_part  = pol_hit[1];
        sel_total = {1'b0, pol_hit[1]} + {1'b0, pol_miss[1]};
      end
      arps_pkg::OP_RATE2: begin
        sel_part  = pol_hit[2];
        sel_total = {1'b0, pol_hit[2]} + {1'b0, pol_miss[2]};
      end
      arps_pkg::OP_DIRTY: begin
        sel_part  = dirty_cnt;
        sel_total = {1'b0, evict_cnt};
      end
      default: ;
    endcase
    if (use_pct) begin
      div_num = 48'(39'(sel_part) * 39'(arps_pkg::PCT_SCALE));
      div_den = sel_total;
    end
  end

  arps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      case (cmd.op)
        arps_pkg::OP_MOD:   mod_zero  <= (div_rem == '0);
        arps_pkg::OP_HIT:   hit_pct   <= PW'(div_quot);
        arps_pkg::OP_ONCE:  once_pct  <= PW'(div_quot);
        arps_pkg::OP_SEQ:   seq_pct   <= PW'(div_quot);
        arps_pkg::OP_AVGH:  avgh      <= div_quot;
        arps_pkg::OP_AVGR:  avgr      <= div_quot;
        arps_pkg::OP_RATE0: rate[0]   <= PW'(div_quot);
        arps_pkg::OP_RATE1: rate[1]   <= PW'(div_quot);
        arps_pkg::OP_RATE2: rate[2]   <= PW'(div_quot);
        arps_pkg::OP_DIRTY: dirty_pct <= PW'(div_quot);
        default: ;
      endcase
    end
  end

  // policy choice from the measured workload
  always_comb begin
    if (seq_pct > arps_pkg::SEQ_HI) begin
      next_pol = arps_pkg::POL_FIFO;
    end else if (once_pct > arps_pkg::ONCE_HI && avgh < arps_pkg::AVGH_LO) begin
      next_pol = arps_pkg::POL_FIFO;
    end else if (avgh > arps_pkg::AVGH_HI && once_pct < arps_pkg::ONCE_LO) begin
      next_pol = arps_pkg::POL_MRU;
    end else if (avgr != '0 && avgr < arps_pkg::REUSE_MAX) begin
      next_pol = arps_pkg::POL_LRU;
    end else if (rate[0] >= rate[1] && rate[0] >= rate[2]) begin
      next_pol = arps_pkg::POL_MRU;
    end else if (rate[1] >= rate[2]) begin
      next_pol = arps_pkg::POL_FIFO;
    end else begin
      next_pol = arps_pkg::POL_LRU;
    end
  end

  assign sts.clear_done    = (clr_addr == AW'(SLOTS - 1));
  assign sts.div_done      = div_done;
  assign sts.gate_ok       = mod_zero && (wacc >= sample_floor)
                             && ((ltime - last_switch) >= min_dwell);
  assign sts.hit_low       = (hit_pct < hit_thr);
  assign sts.switch_needed = (next_pol != active);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      policy   <= cmd.do_switch ? next_pol : active;
      switched <= cmd.do_switch;
      if (cmd.do_switch) begin
        prev_policy     <= active;
        win_hit_pct     <= hit_pct;
        window_accesses <= wacc;
        single_use_pct  <= once_pct;
        seq_run_pct     <= seq_pct;
        hits_per_evict  <= (avgh[SW-1:CW] != '0) ? '1 : avgh[CW-1:0];
        reuse_gap       <= (avgr[SW-1:CW] != '0) ? '1 : avgr[CW-1:0];
        dirty_evict_pct <= dirty_pct;
        prev_policy_pct <= rate[active];
        switch_time     <= ltime;
      end else begin
        prev_policy     <= '0;
        win_hit_pct     <= '0;
        window_accesses <= '0;
        single_use_pct  <= '0;
        seq_run_pct     <= '0;
        hits_per_evict  <= '0;
        reuse_gap       <= '0;
        dirty_evict_pct <= '0;
        prev_policy_pct <= '0;
        switch_time     <= '0;
      end
    end
  end

endmodule

[design/arps_ctrl.sv]
// ----------------------------------------------------------------------------
// arps_ctrl
// Sequencer: clearing pass, metadata read-modify-write, policy check steps.
// ----------------------------------------------------------------------------
module arps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      kind,
  input  arps_pkg::sts_t  sts,
  output arps_pkg::cmd_t  cmd,
  output logic            busy
);

  arps_pkg::state_t  state, state_next;
  arps_pkg::div_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arps_pkg::S_CLEAR;
      op    <= arps_pkg::OP_MOD;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    case (state)
      arps_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = arps_pkg::S_IDLE;
        end
      end
      arps_pkg::S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (kind == arps_pkg::KIND_REQUEST) begin
            op_next    = arps_pkg::OP_MOD;
            state_next = arps_pkg::S_DIV_GO;
          end else begin
            state_next = arps_pkg::S_READ;
          end
        end
      end
      arps_pkg::S_READ: begin
        state_next = arps_pkg::S_UPDATE;
      end
      arps_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = arps_pkg::S_IDLE;
      end
      arps_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = arps_pkg::S_DIV_WAIT;
      end
      arps_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.latch  = 1'b1;
          state_next = arps_pkg::S_GATE;
        end
      end
      arps_pkg::S_GATE: begin
        case (op)
          arps_pkg::OP_MOD: begin
            if (sts.gate_ok) begin
              op_next    = arps_pkg::OP_HIT;
              state_next = arps_pkg::S_DIV_GO;
            end else begin
              cmd.emit   = 1'b1;
              state_next = arps_pkg::S_IDLE;
            end
          end
          arps_pkg::OP_HIT: begin
            if (sts.hit_low) begin
              op_next    = arps_pkg::OP_ONCE;
              state_next = arps_pkg::S_DIV_GO;
            end else begin
              cmd.emit   = 1'b1;
              state_next = arps_pkg::S_IDLE;
            end
          end
          arps_pkg::OP_DIRTY: begin
            cmd.emit      = 1'b1;
            cmd.do_switch = sts.switch_needed;
            state_next    = arps_pkg::S_IDLE;
          end
          default: begin
            // advance to the next ratio
            op_next    = arps_pkg::div_op_t'(op + 4'd1);
            state_next = arps_pkg::S_DIV_GO;
          end
        endcase
      end
      default: begin
        state_next = arps_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != arps_pkg::S_IDLE);

endmodule

[design/adaptive_replacement_policy_selector.sv]
// ----------------------------------------------------------------------------
// adaptive_replacement_policy_selector
// Watches page events and picks the eviction policy on eviction requests.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  event    | start / busy         | kind, slot, file_id, page_offset, dirty
//  result   | done (1-cycle)       | policy, switched, metrics
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Page events go through accept, metadata read, then update and write back.
//  An eviction request runs divider passes: one when the interval, sample or
//  dwell test fails, two when the window hit rate is high enough, ten
//  otherwise (done rises in the cycle in which busy falls).
//  After reset a clearing pass over all SLOTS slots runs with busy high.
//  Results are a one-cycle strobe; the receiver cannot stall. Config is always
//  ready.
// ----------------------------------------------------------------------------
module adaptive_replacement_policy_selector #(
  parameter int SLOTS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [11:0] slot,
  input  logic [31:0] file_id,
  input  logic [31:0] page_offset,
  input  logic        dirty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  policy,
  output logic        switched,
  output logic [1:0]  prev_policy,
  output logic [6:0]  win_hit_pct,
  output logic [31:0] window_accesses,
  output logic [6:0]  single_use_pct,
  output logic [6:0]  seq_run_pct,
  output logic [31:0] hits_per_evict,
  output logic [31:0] reuse_gap,
  output logic [6:0]  dirty_evict_pct,
  output logic [6:0]  prev_policy_pct,
  output logic [31:0] switch_time
);

  arps_pkg::cmd_t cmd;
  arps_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  arps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  arps_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .slot            (slot),
    .file_id         (file_id),
    .page_offset     (page_offset),
    .dirty           (dirty),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .policy          (policy),
    .switched        (switched),
    .prev_policy     (prev_policy),
    .win_hit_pct     (win_hit_pct),
    .window_accesses (window_accesses),
    .single_use_pct  (single_use_pct),
    .seq_run_pct     (seq_run_pct),
    .hits_per_evict  (hits_per_evict),
    .reuse_gap       (reuse_gap),
    .dirty_evict_pct (dirty_evict_pct),
    .prev_policy_pct (prev_policy_pct),
    .switch_time     (switch_time)
  );

endmodule

[design/arps_checker.sv]
// ----------------------------------------------------------------------------
// arps_checker
// Port-level checks on the selector, attached by bind.
// ----------------------------------------------------------------------------
`include "adaptive_replacement_policy_selector_defines.svh"

module arps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        switched,
  input logic [1:0]  policy,
  input logic [6:0]  win_hit_pct,
  input logic [31:0] window_accesses
);

  `ARPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ARPS_ASSERT_NEXT(a_done_pulse, done, !done)
  `ARPS_ASSERT_SAME(a_done_idle, done, !busy)
  `ARPS_ASSERT_SAME(a_quiet_fields, done && !switched, win_hit_pct == '0 && window_accesses == '0)
  `ARPS_ASSERT_SAME(a_policy_code, done, policy <= arps_pkg::POL_LRU)

endmodule

bind adaptive_replacement_policy_selector arps_checker u_arps_checker (.*);
